/* rtl/core/arpr_pkg.sv */
package arpr_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CMP_WIDTH = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	localparam logic [1:0] FUNC_RESOLVE = 2'd0;
	localparam logic [1:0] FUNC_HEADER  = 2'd1;
	localparam logic [1:0] FUNC_TICK    = 2'd2;

	localparam logic [1:0] KIND_REPLY    = 2'd0;
	localparam logic [1:0] KIND_REQUEST  = 2'd1;
	localparam logic [1:0] KIND_RESOLVED = 2'd2;
	localparam logic [1:0] KIND_FAILED   = 2'd3;

	localparam logic [1:0] OPC_REQUEST = 2'd1;
	localparam logic [1:0] OPC_REPLY   = 2'd2;

	localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
	localparam logic [15:0] PROTO_IPV4    = 16'h0800;
	localparam logic [15:0] HW_ETHERNET   = 16'd1;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;
	localparam logic [15:0] ARP_OP_REP    = 16'd2;

	localparam logic [1:0] REG_LOCAL_IP        = 2'd0;
	localparam logic [1:0] REG_LOCAL_MAC       = 2'd1;
	localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd2;
	localparam logic [1:0] REG_RESOLVE_TIMEOUT = 2'd3;

	localparam logic [15:0] RETRY_INTERVAL_RST  = 16'd250;
	localparam logic [15:0] RESOLVE_TIMEOUT_RST = 16'd2000;

	localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] resolve_ip;
		logic [15:0] frame_type;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [15:0] arp_opcode_in;
		logic [47:0] packet_sender_mac;
		logic [31:0] packet_sender_ip;
		logic [31:0] packet_target_ip;
	} arpr_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [47:0] frame_dest_mac;
		logic [1:0]  arp_opcode_out;
		logic [31:0] arp_target_ip;
		logic [47:0] arp_target_mac;
		logic [47:0] found_mac;
	} arpr_result_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [47:0] local_mac;
		logic [15:0] retry_interval;
		logic [15:0] resolve_timeout;
	} arpr_cfg_t;

	typedef struct packed {
		logic resolving;
	} arpr_status_t;

endpackage

/* rtl/core/arpr_if.sv */
interface arpr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] resolve_ip;
	logic [15:0] frame_type;
	logic [15:0] hw_type;
	logic [15:0] proto_type;
	logic [15:0] arp_opcode_in;
	logic [47:0] packet_sender_mac;
	logic [31:0] packet_sender_ip;
	logic [31:0] packet_target_ip;

	modport source (output valid, func, resolve_ip, frame_type, hw_type, proto_type,
		arp_opcode_in, packet_sender_mac, packet_sender_ip, packet_target_ip,
		input ready);
	modport sink (input valid, func, resolve_ip, frame_type, hw_type, proto_type,
		arp_opcode_in, packet_sender_mac, packet_sender_ip, packet_target_ip,
		output ready);
endinterface

interface arpr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [47:0] frame_dest_mac;
	logic [1:0]  arp_opcode_out;
	logic [31:0] arp_target_ip;
	logic [47:0] arp_target_mac;
	logic [47:0] found_mac;

	modport source (output valid, out_kind, frame_dest_mac, arp_opcode_out, arp_target_ip,
		arp_target_mac, found_mac, input ready);
	modport sink (input valid, out_kind, frame_dest_mac, arp_opcode_out, arp_target_ip,
		arp_target_mac, found_mac, output ready);
endinterface

interface arpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/arpr_engine.sv */
module arpr_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  act,
	input  arpr_pkg::arpr_item_t  item,
	input  arpr_pkg::arpr_cfg_t   cfg,
	output logic                  res_valid,
	output arpr_pkg::arpr_result_t res,
	output arpr_pkg::arpr_status_t status
);
	import arpr_pkg::*;

	localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

	logic                   resolving_q, resolving_d;
	logic [31:0]            pending_ip_q, pending_ip_d;
	logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
	logic [TIMER_WIDTH-1:0] since_q, since_d;
	logic [TIMER_WIDTH-1:0] elapsed_inc, since_inc;
	logic                   hdr_arp;

	assign elapsed_inc = (elapsed_q == TMAX) ? elapsed_q : elapsed_q + 1'b1;
	assign since_inc   = (since_q == TMAX) ? since_q : since_q + 1'b1;
	assign hdr_arp     = (item.frame_type == ETHERTYPE_ARP) && (item.proto_type == PROTO_IPV4);

	always_comb begin
		resolving_d  = resolving_q;
		pending_ip_d = pending_ip_q;
		elapsed_d    = elapsed_q;
		since_d      = since_q;
		res_valid    = 1'b0;
		res.out_kind       = KIND_REQUEST;
		res.frame_dest_mac = MAC_BROADCAST;
		res.arp_opcode_out = OPC_REQUEST;
		res.arp_target_ip  = pending_ip_q;
		res.arp_target_mac = '0;
		res.found_mac      = '0;
		case (item.func)
			FUNC_RESOLVE: begin
				if (!resolving_q) begin
					resolving_d       = 1'b1;
					pending_ip_d      = item.resolve_ip;
					elapsed_d         = '0;
					since_d           = '0;
					res_valid         = 1'b1;
					res.arp_target_ip = item.resolve_ip;
				end
			end
			FUNC_HEADER: begin
				if (resolving_q) begin
					if (hdr_arp && item.arp_opcode_in == ARP_OP_REP &&
					    item.packet_sender_ip == pending_ip_q) begin
						resolving_d        = 1'b0;
						res_valid          = 1'b1;
						res.out_kind       = KIND_RESOLVED;
						res.frame_dest_mac = '0;
						res.arp_opcode_out = OPC_REPLY;
						res.found_mac      = item.packet_sender_mac;
					end
				end else if (hdr_arp && item.hw_type == HW_ETHERNET &&
				             item.arp_opcode_in == ARP_OP_REQ &&
				             item.packet_target_ip == cfg.local_ip) begin
					res_valid          = 1'b1;
					res.out_kind       = KIND_REPLY;
					res.frame_dest_mac = item.packet_sender_mac;
					res.arp_opcode_out = OPC_REPLY;
					res.arp_target_ip  = item.packet_sender_ip;
					res.arp_target_mac = item.packet_sender_mac;
				end
			end
			FUNC_TICK: begin
				if (resolving_q) begin
					elapsed_d = elapsed_inc;
					since_d   = since_inc;
					if (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(cfg.resolve_timeout)) begin
						resolving_d        = 1'b0;
						res_valid          = 1'b1;
						res.out_kind       = KIND_FAILED;
						res.frame_dest_mac = '0;
					end else if (CMP_WIDTH'(since_inc) >= CMP_WIDTH'(cfg.retry_interval)) begin
						since_d   = '0;
						res_valid = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolving_q  <= 1'b0;
			pending_ip_q <= '0;
			elapsed_q    <= '0;
			since_q      <= '0;
		end else if (act) begin
			resolving_q  <= resolving_d;
			pending_ip_q <= pending_ip_d;
			elapsed_q    <= elapsed_d;
			since_q      <= since_d;
		end
	end

	assign status.resolving = resolving_q;

endmodule

/* rtl/core/arp_responder_resolver_top.sv */
// ARP responder/resolver: answers requests for the local IP, resolves one target at a time.
// Each item passes through the input reg, then the result reg, before its result is valid.
// Throughput: one item per cycle; a held result stalls the input only when both regs are full.
// Reset (arst_n low, async): idle, no items held, timers cleared,
// retry_interval 250, resolve_timeout 2000, local_ip and local_mac zero.
module arp_responder_resolver_top (
	input  logic     clk,
	input  logic     arst_n,
	arpr_in_if.sink  req,
	arpr_out_if.source rsp,
	arpr_cfg_if.sink cfg
);
	import arpr_pkg::*;

	// config registers; the user must write them only while no item is in flight; the block does not enforce it
	arpr_cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip        <= '0;
			cfg_q.local_mac       <= '0;
			cfg_q.retry_interval  <= RETRY_INTERVAL_RST;
			cfg_q.resolve_timeout <= RESOLVE_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOCAL_IP:        cfg_q.local_ip        <= cfg.data[31:0];
				REG_LOCAL_MAC:       cfg_q.local_mac       <= cfg.data;
				REG_RETRY_INTERVAL:  cfg_q.retry_interval  <= cfg.data[15:0];
				REG_RESOLVE_TIMEOUT: cfg_q.resolve_timeout <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	// input register stage
	arpr_item_t item_s1;
	logic       valid_s1;
	logic       advance;
	logic       out_valid_q;
	arpr_result_t out_q;

	// stage 1 moves on whenever the result register is empty or being drained
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func              <= req.func;
			item_s1.resolve_ip        <= req.resolve_ip;
			item_s1.frame_type        <= req.frame_type;
			item_s1.hw_type           <= req.hw_type;
			item_s1.proto_type        <= req.proto_type;
			item_s1.arp_opcode_in     <= req.arp_opcode_in;
			item_s1.packet_sender_mac <= req.packet_sender_mac;
			item_s1.packet_sender_ip  <= req.packet_sender_ip;
			item_s1.packet_target_ip  <= req.packet_target_ip;
		end
	end

	// decision logic and resolver state; state commits when the item advances
	logic         res_valid;
	arpr_result_t res;
	arpr_status_t status;

	arpr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.act       (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	// result register; items that cause no result leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.out_kind       = out_q.out_kind;
	assign rsp.frame_dest_mac = out_q.frame_dest_mac;
	assign rsp.arp_opcode_out = out_q.arp_opcode_out;
	assign rsp.arp_target_ip  = out_q.arp_target_ip;
	assign rsp.arp_target_mac = out_q.arp_target_mac;
	assign rsp.found_mac      = out_q.found_mac;

`ifndef NO_ASSERTIONS
	// request frames always go out as broadcast ARP requests
	a_req_form: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.out_kind == KIND_REQUEST) |->
		(rsp.frame_dest_mac == MAC_BROADCAST && rsp.arp_opcode_out == OPC_REQUEST))
		else $error("request frame malformed");

	// a resolve that ends leaves the engine idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && (res.out_kind == KIND_RESOLVED ||
		 res.out_kind == KIND_FAILED)) |=> !status.resolving)
		else $error("resolver still busy after resolve ended");

	// replies to peers are only generated while idle
	a_reply_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.out_kind == KIND_REPLY) |-> !status.resolving)
		else $error("reply generated while resolving");

	// a resolve taken while idle starts the resolver; one that arrives while resolving is ignored
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && item_s1.func == FUNC_RESOLVE) |=> status.resolving)
		else $error("resolve did not start");
`endif

endmodule
